// ===== design/ptmq_pkg.sv =====
// Package for the per-task message queues: sizes, status codes and the control state type.
package ptmq_pkg;

   localparam int QUEUE_COUNT = 8;
   localparam int QUEUE_DEPTH = 8;
   localparam int MSG_BYTES   = 32;

   localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
   localparam int SW = $clog2(QUEUE_DEPTH);
   localparam int PW = $clog2(MSG_BYTES);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = QW + SW + PW;
   localparam int STORE_DEPTH = 1 << AW;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_BADQ  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_TERM,
      S_POP
   } state_type;

endpackage

// ===== design/per_task_message_queues.sv =====
// Per-task message queues: a set of circular FIFOs of zero-terminated byte strings.
//
// Input channel (req_*): one item per transfer. op=0 pushes one byte of a message run,
// the final byte marked with req_last; the first byte picks the queue and decides
// whether the message is kept (bad queue or full queue drops it whole). op=1 pops the
// oldest message of req_queue_id.
// Result channel (rsp_*): a push run yields one status on its last byte; a pop yields
// the message bytes then a zero byte with rsp_end_of_run set, or one error status.
// Timing: a push byte that is not last leaves the block in S_IDLE. A last byte that commits
// a message also passes through S_TERM (the terminator write needs the store's single write
// port). A pop reads its first byte through the store's registered read, then streams one
// byte per cycle while the output is not stalled, set by the message store's one read port.
// Results pass through one output register; while a result is stalled, req_stall stays
// high and no item of any kind enters until that result is taken.
// Reset clears all queue pointers and counts and any open push run; the message store
// itself needs no clearing, since every committed slot holds its own terminator.
module per_task_message_queues import ptmq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_op,
   input  logic signed [7:0] req_queue_id,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_end_of_run
);

   state_type state_ff, state_in;

   logic [SW-1:0] rd_idx_ff [QUEUE_COUNT];
   logic [SW-1:0] wr_idx_ff [QUEUE_COUNT];
   logic [FW-1:0] fill_ff   [QUEUE_COUNT];

   logic          run_active_ff, run_active_in;
   logic [1:0]    run_status_ff, run_status_in;
   logic [QW-1:0] run_queue_ff,  run_queue_in;
   logic [SW-1:0] run_slot_ff,   run_slot_in;
   logic [PW-1:0] run_pos_ff,    run_pos_in;
   logic          run_term_ff,   run_term_in;

   logic [QW-1:0] pop_queue_ff, pop_queue_in;
   logic [SW-1:0] pop_slot_ff,  pop_slot_in;
   logic [PW-1:0] pop_pos_ff,   pop_pos_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [7:0]    rsp_byte_ff,   rsp_byte_in;
   logic          rsp_end_ff,    rsp_end_in;

   logic          out_free;
   logic          accept;
   logic          q_ok;
   logic [QW-1:0] req_q;
   logic [QW-1:0] qsel;
   logic [SW-1:0] sel_rd_idx;
   logic [SW-1:0] sel_wr_idx;
   logic [FW-1:0] sel_fill;

   logic          first;
   logic [1:0]    eff_status;
   logic [QW-1:0] eff_queue;
   logic [SW-1:0] eff_slot;
   logic [PW-1:0] eff_pos;
   logic          eff_term;
   logic          store;

   logic          rd_upd, wr_upd, fill_upd;
   logic [SW-1:0] slot_new;
   logic [FW-1:0] fill_new;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [7:0]    mem_wr_data;
   logic [AW-1:0] mem_rd_addr;
   logic [7:0]    mem_rd_data;
   logic          pop_end;

   function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
      return (s == SW'(QUEUE_DEPTH - 1)) ? '0 : s + SW'(1);
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   assign q_ok  = !req_queue_id[7] && (req_queue_id[6:0] < 7'(QUEUE_COUNT));
   assign req_q = q_ok ? req_queue_id[QW-1:0] : '0;

   always_comb begin
      unique case (state_ff)
         S_IDLE:  qsel = req_q;
         S_POP:   qsel = pop_queue_ff;
         S_TERM:  qsel = run_queue_ff;
         default: qsel = '0;
      endcase
   end

   assign sel_rd_idx = rd_idx_ff[qsel];
   assign sel_wr_idx = wr_idx_ff[qsel];
   assign sel_fill   = fill_ff[qsel];

   // Effective run state for a push byte: the first byte of a run opens it.
   assign first      = !run_active_ff;
   assign eff_status = first ? (q_ok ? ((sel_fill == FW'(QUEUE_DEPTH)) ? ST_FULL : ST_OK)
                                     : ST_BADQ)
                             : run_status_ff;
   assign eff_queue  = first ? req_q : run_queue_ff;
   assign eff_slot   = first ? sel_wr_idx : run_slot_ff;
   assign eff_pos    = first ? '0 : run_pos_ff;
   assign eff_term   = first ? 1'b0 : run_term_ff;
   assign store      = (eff_status == ST_OK) && !eff_term && (req_data_byte != 8'd0) &&
                       (eff_pos < PW'(MSG_BYTES - 1));

   assign pop_end = (mem_rd_data == 8'd0) || (pop_pos_ff == PW'(MSG_BYTES - 1));

   always_comb begin
      state_in      = state_ff;
      run_active_in = run_active_ff;
      run_status_in = run_status_ff;
      run_queue_in  = run_queue_ff;
      run_slot_in   = run_slot_ff;
      run_pos_in    = run_pos_ff;
      run_term_in   = run_term_ff;
      pop_queue_in  = pop_queue_ff;
      pop_slot_in   = pop_slot_ff;
      pop_pos_in    = pop_pos_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_end_in    = rsp_end_ff;
      rd_upd        = 1'b0;
      wr_upd        = 1'b0;
      fill_upd      = 1'b0;
      slot_new      = '0;
      fill_new      = sel_fill;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = {eff_queue, eff_slot, eff_pos};
      mem_wr_data   = req_data_byte;
      mem_rd_addr   = {qsel, sel_rd_idx, PW'(0)};

      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_op == OP_POP) begin
               if (!q_ok || sel_fill == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = q_ok ? ST_EMPTY : ST_BADQ;
                  rsp_byte_in   = 8'd0;
                  rsp_end_in    = 1'b1;
               end else begin
                  pop_queue_in = req_q;
                  pop_slot_in  = sel_rd_idx;
                  pop_pos_in   = '0;
                  state_in     = S_POP;
               end
            end else if (accept) begin
               mem_wr_en     = store;
               run_active_in = 1'b1;
               run_status_in = eff_status;
               run_queue_in  = eff_queue;
               run_slot_in   = eff_slot;
               run_pos_in    = eff_pos + PW'(store);
               run_term_in   = eff_term || (eff_status == ST_OK && req_data_byte == 8'd0);
               if (req_last) begin
                  if (eff_status == ST_OK) begin
                     state_in = S_TERM;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = eff_status;
                     rsp_byte_in   = 8'd0;
                     rsp_end_in    = 1'b1;
                     run_active_in = 1'b0;
                     run_status_in = ST_OK;
                     run_queue_in  = '0;
                     run_pos_in    = '0;
                     run_term_in   = 1'b0;
                  end
               end
            end
         end
         S_TERM: begin
            // Terminator write and commit of the message slot.
            mem_wr_addr = {run_queue_ff, run_slot_ff, run_pos_ff};
            mem_wr_data = 8'd0;
            if (out_free) begin
               mem_wr_en     = 1'b1;
               wr_upd        = 1'b1;
               fill_upd      = 1'b1;
               slot_new      = slot_next(run_slot_ff);
               fill_new      = sel_fill + FW'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_byte_in   = 8'd0;
               rsp_end_in    = 1'b1;
               run_active_in = 1'b0;
               run_status_in = ST_OK;
               run_queue_in  = '0;
               run_pos_in    = '0;
               run_term_in   = 1'b0;
               state_in      = S_IDLE;
            end
         end
         S_POP: begin
            // Read data is for pop_pos_ff; when a byte is sent, the address runs one position ahead.
            mem_rd_addr = {pop_queue_ff, pop_slot_ff, pop_pos_ff};
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_byte_in   = pop_end ? 8'd0 : mem_rd_data;
               rsp_end_in    = pop_end;
               if (pop_end) begin
                  rd_upd   = 1'b1;
                  fill_upd = 1'b1;
                  slot_new = slot_next(pop_slot_ff);
                  fill_new = sel_fill - FW'(1);
                  state_in = S_IDLE;
               end else begin
                  pop_pos_in  = pop_pos_ff + PW'(1);
                  mem_rd_addr = {pop_queue_ff, pop_slot_ff, pop_pos_in};
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         run_active_ff <= 1'b0;
         run_status_ff <= ST_OK;
         run_queue_ff  <= '0;
         run_pos_ff    <= '0;
         run_term_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < QUEUE_COUNT; i++) begin
            rd_idx_ff[i] <= '0;
            wr_idx_ff[i] <= '0;
            fill_ff[i]   <= '0;
         end
      end else begin
         state_ff      <= state_in;
         run_active_ff <= run_active_in;
         run_status_ff <= run_status_in;
         run_queue_ff  <= run_queue_in;
         run_pos_ff    <= run_pos_in;
         run_term_ff   <= run_term_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (rd_upd) begin
            rd_idx_ff[qsel] <= slot_new;
         end
         if (wr_upd) begin
            wr_idx_ff[qsel] <= slot_new;
         end
         if (fill_upd) begin
            fill_ff[qsel] <= fill_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      run_slot_ff   <= run_slot_in;
      pop_queue_ff  <= pop_queue_in;
      pop_slot_ff   <= pop_slot_in;
      pop_pos_ff    <= pop_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_end_ff    <= rsp_end_in;
   end

   ptmq_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_end_of_run = rsp_end_ff;

endmodule

// ===== design/ptmq_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ptmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
